@@ rtl/rbme_pkg.sv @@
// Shared opcodes, write kinds and the decoded request type for the execute unit.
package rbme_pkg;

    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BGT   = 6'h06;
    localparam logic [5:0] OP_BGE   = 6'h09;
    localparam logic [5:0] OP_BLT   = 6'h01;
    localparam logic [5:0] OP_BLE   = 6'h0B;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_FBGT  = 6'h07;
    localparam logic [5:0] OP_FBGE  = 6'h0E;
    localparam logic [5:0] OP_FBNE  = 6'h03;
    localparam logic [5:0] OP_ILW   = 6'h2F;
    localparam logic [5:0] OP_ILWF  = 6'h27;
    localparam logic [5:0] OP_ISW   = 6'h37;
    localparam logic [5:0] OP_ISWF  = 6'h3B;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h18;
    localparam logic [5:0] OP_JALR  = 6'h38;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_LWF   = 6'h24;
    localparam logic [5:0] OP_SLL   = 6'h3F;
    localparam logic [5:0] OP_SLLI  = 6'h3E;
    localparam logic [5:0] OP_SW    = 6'h2B;
    localparam logic [5:0] OP_SWF   = 6'h2C;

    localparam logic [2:0] WK_NONE = 3'd0;
    localparam logic [2:0] WK_INT  = 3'd1;
    localparam logic [2:0] WK_FLT  = 3'd2;
    localparam logic [2:0] WK_DMEM = 3'd3;
    localparam logic [2:0] WK_IMEM = 3'd4;

    localparam logic [4:0] LINK_REG = 5'd28;

    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sa;
        logic [31:0] imm;
        logic [25:0] target;
        logic        recog;
    } dec_t;

    function automatic logic f_is_nan(input logic [31:0] x);
        return x[30:0] > 31'h7F800000;
    endfunction

    function automatic logic [31:0] f_key(input logic [31:0] x);
        return x[31] ? ~x : (x | 32'h80000000);
    endfunction

    // Mode 0 is greater, mode 1 greater or equal, mode 2 not equal.
    function automatic logic f_cmp(input logic [31:0] a, input logic [31:0] b,
                                   input logic [1:0] mode);
        logic nan;
        logic eq;
        logic res;
        nan = f_is_nan(a) || f_is_nan(b);
        eq  = !nan && ((((a | b) & 32'h7FFFFFFF) == 32'd0) || (a == b));
        if (mode == 2'd2)
        begin
            res = !eq;
        end
        else if (nan)
        begin
            res = 1'b0;
        end
        else if (eq)
        begin
            res = (mode == 2'd1);
        end
        else
        begin
            res = f_key(a) > f_key(b);
        end
        return res;
    endfunction

endpackage

@@ rtl/risc_immediate_branch_memory_executor_unit.sv @@
// Top level of the execute unit: decode front end and execution back end.
// A request passes the front-end register and then the result register.
// Non-load requests are taken one per cycle while results are popped; loads
// block new requests in the memory state behind the registered memory reads.
// Reset clears the pc, both register files and all valid state at once.
// The memories are not cleared; their contents are undefined until written.
module risc_immediate_branch_memory_executor_unit
    import rbme_pkg::*;
#(
    parameter int DATA_WORDS = 4096,
    parameter int IMEM_WORDS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] instr_word,
    output logic        empty,
    input  logic        pop,
    output logic [25:0] next_pc,
    output logic        redirected,
    output logic [2:0]  write_kind,
    output logic [11:0] write_index,
    output logic [31:0] write_value,
    output logic        recognized
);
    logic dec_valid;
    logic dec_take;
    dec_t dec;
    logic res_valid;

    rbme_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .instr_word (instr_word),
        .dec_valid  (dec_valid),
        .dec        (dec),
        .dec_take   (dec_take)
    );

    rbme_back #(
        .DATA_WORDS (DATA_WORDS),
        .IMEM_WORDS (IMEM_WORDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .dec_valid   (dec_valid),
        .dec         (dec),
        .dec_take    (dec_take),
        .res_valid   (res_valid),
        .res_take    (pop && !empty),
        .next_pc     (next_pc),
        .redirected  (redirected),
        .write_kind  (write_kind),
        .write_index (write_index),
        .write_value (write_value),
        .recognized  (recognized)
    );

    assign empty = !res_valid;

    a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dec_take |-> dec_valid)
        else $error("back end took a request that was not there");

    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (write_kind == WK_NONE)) |-> (write_value == 32'd0))
        else $error("result without a write carries a value");

    a_full_means_held: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> dec_valid)
        else $error("front end full without a held request");
endmodule

@@ rtl/rbme_front.sv @@
// Front end: accepts instruction requests and decodes their fields.
module rbme_front
    import rbme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] instr_word,
    output logic        dec_valid,
    output dec_t        dec,
    input  logic        dec_take
);
    logic valid_reg;
    logic valid_next;
    dec_t dec_reg;
    dec_t dec_next;
    logic accept;

    assign full   = valid_reg && !dec_take;
    assign accept = push && !full;

    always_comb
    begin
        dec_next.op     = instr_word[31:26];
        dec_next.rs     = instr_word[25:21];
        dec_next.rt     = instr_word[20:16];
        dec_next.rd     = instr_word[15:11];
        dec_next.sa     = instr_word[10:6];
        dec_next.imm    = {{16{instr_word[15]}}, instr_word[15:0]};
        dec_next.target = instr_word[25:0];
        case (instr_word[31:26]) inside
            OP_ADDI, OP_BEQ, OP_BGT, OP_BGE, OP_BLT, OP_BLE, OP_BNE, OP_FBGT,
            OP_FBGE, OP_FBNE, OP_ILW, OP_ILWF, OP_ISW, OP_ISWF, OP_J, OP_JAL,
            OP_JALR, OP_LW, OP_LWF, OP_SLL, OP_SLLI, OP_SW, OP_SWF:
                dec_next.recog = 1'b1;
            default:
                dec_next.recog = 1'b0;
        endcase
        valid_next = accept || (valid_reg && !dec_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;
endmodule

@@ rtl/rbme_back.sv @@
// Back end: reads operands, accesses the memories and writes back state.
module rbme_back
    import rbme_pkg::*;
#(
    parameter int DATA_WORDS = 4096,
    parameter int IMEM_WORDS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        dec_valid,
    input  dec_t        dec,
    output logic        dec_take,
    output logic        res_valid,
    input  logic        res_take,
    output logic [25:0] next_pc,
    output logic        redirected,
    output logic [2:0]  write_kind,
    output logic [11:0] write_index,
    output logic [31:0] write_value,
    output logic        recognized
);
    localparam int DAW = $clog2(DATA_WORDS);
    localparam int IAW = $clog2(IMEM_WORDS);

    typedef enum logic [1:0] {
        ST_EXEC = 2'b01,
        ST_MEM  = 2'b10
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [25:0] pc_reg;
    logic [25:0] pc_next;
    logic [31:0] ireg [32];
    logic [31:0] freg [32];
    logic [31:0] dmem [DATA_WORDS];
    logic [31:0] imem [IMEM_WORDS];
    logic [31:0] drd_reg;
    logic [31:0] ird_reg;

    logic        rv_reg;
    logic        rv_next;
    logic [25:0] o_pc_reg;
    logic        o_redir_reg;
    logic [2:0]  o_kind_reg;
    logic [11:0] o_idx_reg;
    logic [31:0] o_val_reg;
    logic        o_recog_reg;
    logic        o_fromi_reg;

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] fa;
    logic [31:0] fb;
    logic [31:0] addr;
    logic [DAW-1:0] daddr;
    logic [IAW-1:0] iaddr;
    logic [31:0] shamt_r;
    logic [31:0] neg_imm;
    logic        take;
    logic        out_free;
    logic        fire;
    logic        is_load;
    logic        from_imem;
    logic [25:0] n_pc;
    logic        n_redir;
    logic [2:0]  n_kind;
    logic [11:0] n_idx;
    logic [31:0] n_val;

    assign a       = ireg[dec.rs];
    assign b       = ireg[dec.rt];
    assign fa      = freg[dec.rs];
    assign fb      = freg[dec.rt];
    assign addr    = a + dec.imm;
    assign daddr   = addr[DAW-1:0];
    assign iaddr   = addr[IAW-1:0];
    assign shamt_r = ireg[dec.sa];
    assign neg_imm = 32'd0 - dec.imm;

    assign out_free = !rv_reg || res_take;
    assign fire     = dec_valid && (state_reg == ST_EXEC) && out_free;
    assign dec_take = fire;

    always_comb
    begin
        take      = 1'b0;
        is_load   = 1'b0;
        from_imem = 1'b0;
        n_kind    = WK_NONE;
        n_idx     = 12'd0;
        n_val     = 32'd0;
        n_redir   = 1'b0;
        n_pc      = pc_reg + 26'd1;
        case (dec.op)
            OP_ADDI:
            begin
                n_kind = WK_INT;
                n_idx  = {7'd0, dec.rt};
                n_val  = addr;
            end
            OP_BEQ:  take = (a == b);
            OP_BGT:  take = ($signed(a) > $signed(b));
            OP_BGE:  take = ($signed(a) >= $signed(b));
            OP_BLT:  take = ($signed(a) < $signed(b));
            OP_BLE:  take = ($signed(a) <= $signed(b));
            OP_BNE:  take = (a != b);
            OP_FBGT: take = f_cmp(fa, fb, 2'd0);
            OP_FBGE: take = f_cmp(fa, fb, 2'd1);
            OP_FBNE: take = f_cmp(fa, fb, 2'd2);
            OP_ILW, OP_ILWF:
            begin
                n_kind    = (dec.op == OP_ILW) ? WK_INT : WK_FLT;
                n_idx     = {7'd0, dec.rt};
                is_load   = 1'b1;
                from_imem = 1'b1;
            end
            OP_LW, OP_LWF:
            begin
                n_kind  = (dec.op == OP_LW) ? WK_INT : WK_FLT;
                n_idx   = {7'd0, dec.rt};
                is_load = 1'b1;
            end
            OP_ISW, OP_ISWF:
            begin
                n_kind = WK_IMEM;
                n_idx  = 12'(iaddr);
                n_val  = (dec.op == OP_ISW) ? b : fb;
            end
            OP_SW, OP_SWF:
            begin
                n_kind = WK_DMEM;
                n_idx  = 12'(daddr);
                n_val  = (dec.op == OP_SW) ? b : fb;
            end
            OP_J:
            begin
                n_pc    = dec.target;
                n_redir = 1'b1;
            end
            OP_JAL:
            begin
                n_kind  = WK_INT;
                n_idx   = {7'd0, LINK_REG};
                n_val   = {6'd0, pc_reg};
                n_pc    = dec.target;
                n_redir = 1'b1;
            end
            OP_JALR:
            begin
                n_kind  = WK_INT;
                n_idx   = {7'd0, LINK_REG};
                n_val   = {6'd0, pc_reg};
                n_pc    = (dec.rs == LINK_REG) ? pc_reg : a[25:0];
                n_redir = 1'b1;
            end
            OP_SLL:
            begin
                n_kind = WK_INT;
                n_idx  = {7'd0, dec.rd};
                n_val  = (shamt_r >= 32'd32) ? 32'd0 : (b << shamt_r[4:0]);
            end
            OP_SLLI:
            begin
                n_kind = WK_INT;
                n_idx  = {7'd0, dec.rt};
                if (dec.imm[31])
                begin
                    n_val = (neg_imm >= 32'd32) ? 32'd0 : (a >> neg_imm[4:0]);
                end
                else
                begin
                    n_val = (dec.imm >= 32'd32) ? 32'd0 : (a << dec.imm[4:0]);
                end
            end
            default: ;
        endcase
        if (take)
        begin
            n_pc    = pc_reg + dec.imm[25:0];
            n_redir = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        rv_next    = rv_reg;
        case (state_reg)
            ST_EXEC:
            begin
                if (res_take)
                begin
                    rv_next = 1'b0;
                end
                if (fire)
                begin
                    pc_next = n_pc;
                    if (is_load)
                    begin
                        state_next = ST_MEM;
                    end
                    else
                    begin
                        rv_next = 1'b1;
                    end
                end
            end
            ST_MEM:
            begin
                state_next = ST_EXEC;
                rv_next    = 1'b1;
            end
            default:
            begin
                state_next = ST_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EXEC;
            pc_reg    <= 26'd0;
            rv_reg    <= 1'b0;
            for (int i = 0; i < 32; i++)
            begin
                ireg[i] <= 32'd0;
                freg[i] <= 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            rv_reg    <= rv_next;
            if (fire && !is_load && (n_kind == WK_INT))
            begin
                ireg[n_idx[4:0]] <= n_val;
            end
            if (state_reg == ST_MEM)
            begin
                if (o_kind_reg == WK_INT)
                begin
                    ireg[o_idx_reg[4:0]] <= o_fromi_reg ? ird_reg : drd_reg;
                end
                else
                begin
                    freg[o_idx_reg[4:0]] <= o_fromi_reg ? ird_reg : drd_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            o_pc_reg    <= n_pc;
            o_redir_reg <= n_redir;
            o_kind_reg  <= n_kind;
            o_idx_reg   <= n_idx;
            o_val_reg   <= n_val;
            o_recog_reg <= dec.recog;
            o_fromi_reg <= from_imem;
        end
        else if (state_reg == ST_MEM)
        begin
            o_val_reg <= o_fromi_reg ? ird_reg : drd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && (n_kind == WK_DMEM))
        begin
            dmem[daddr] <= n_val;
        end
        drd_reg <= dmem[daddr];
    end

    always_ff @(posedge clk)
    begin
        if (fire && (n_kind == WK_IMEM))
        begin
            imem[iaddr] <= n_val;
        end
        ird_reg <= imem[iaddr];
    end

    assign res_valid   = rv_reg;
    assign next_pc     = o_pc_reg;
    assign redirected  = o_redir_reg;
    assign write_kind  = o_kind_reg;
    assign write_index = o_idx_reg;
    assign write_value = o_val_reg;
    assign recognized  = o_recog_reg;
endmodule
